// File: rtl/core/assert_macros.svh
// assertion macros for the rtl files
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge, off while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// property checked on every rising clk edge, also during reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/core/mbrc_pkg.sv
// package for the modbus rtu response checker: payload structs, error codes,
// size constants and the crc-16 byte update; no dependencies
`timescale 1ns / 1ps

package mbrc_pkg;

	localparam int BUFFER_BYTES = 2048;
	localparam int COUNT_W      = 11;
	localparam int COUNT_CAP    = ((BUFFER_BYTES - 1) < 2047) ? (BUFFER_BYTES - 1) : 2047;
	localparam int CFG_INDEX_W  = 4;
	localparam int CFG_DATA_W   = 11;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [7:0]         EXP_ADDR_RST = 8'd1;
	localparam logic               STRICT_RST   = 1'b1;
	localparam logic [7:0]         MIN_LEN_RST  = 8'd5;
	localparam logic [COUNT_W-1:0] MAX_LEN_RST  = 11'd20;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_EXP_ADDR = 4'd0,
		REG_STRICT   = 4'd1,
		REG_MIN_LEN  = 4'd2,
		REG_MAX_LEN  = 4'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ERR_OK    = 3'd0,
		ERR_SHORT = 3'd1,
		ERR_LONG  = 3'd2,
		ERR_ADDR  = 3'd3,
		ERR_ZERO  = 3'd4,
		ERR_CRC   = 3'd5
	} err_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic               frame_ok;
		logic [2:0]         error_code;
		logic [COUNT_W-1:0] byte_count;
	} result_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// File: rtl/core/modbus_rtu_response_checker.sv
// modbus rtu response checker: byte counting, crc-16 and frame checks
// depends on mbrc_pkg and assert_macros.svh
`timescale 1ns / 1ps

// Takes one response byte per clock at full rate unless intake stalls. A byte
// is registered on transfer, and when it leaves the input register the frame
// state (count, address, function, two-byte trailer delay, crc) is updated by
// one eight-step crc-16 byte update. A byte flagged last writes its result to
// the output register when it leaves the input register; frame state then
// clears so the next byte may start a new response. Intake stalls only while a
// result waits in the output register and another last byte is ready to report.
// The count saturates at 2047 bytes; further bytes are dropped but a last flag
// still closes the response. Configuration writes are always ready and must only
// be issued while the block is idle.
module modbus_rtu_response_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  mbrc_pkg::item_t                     item_data,
	output logic                                result_valid,
	input  logic                                result_stall,
	output mbrc_pkg::result_t                   result_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mbrc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [mbrc_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import mbrc_pkg::*;

	`include "assert_macros.svh"

	logic [7:0]         exp_addr_q;
	logic               strict_q;
	logic [7:0]         min_len_q;
	logic [COUNT_W-1:0] max_len_q;

	logic               valid_s1;
	item_t              item_s1;

	logic [15:0]        crc_q;
	logic [7:0]         d0_q;
	logic [7:0]         d1_q;
	logic [COUNT_W-1:0] count_q;
	logic [7:0]         addr_q;
	logic [7:0]         func_q;

	logic               res_valid_q;
	result_t            res_q;

	logic               advance;
	logic               take;
	logic [COUNT_W-1:0] count_nx;
	logic [7:0]         addr_nx;
	logic [7:0]         func_nx;
	logic [15:0]        crc_nx;
	logic [7:0]         d0_nx;
	logic [7:0]         d1_nx;
	logic signed [8:0]  sum_af;
	err_t               err;

	// config registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_addr_q <= EXP_ADDR_RST;
			strict_q   <= STRICT_RST;
			min_len_q  <= MIN_LEN_RST;
			max_len_q  <= MAX_LEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_EXP_ADDR: exp_addr_q <= cfg_data[7:0];
				REG_STRICT:   strict_q   <= cfg_data[0];
				REG_MIN_LEN:  min_len_q  <= cfg_data[7:0];
				REG_MAX_LEN:  max_len_q  <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	assign advance    = valid_s1 && (!item_s1.last_byte || !res_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item_data;
		end
	end

	// frame state update
	always_comb begin
		take     = count_q < COUNT_W'(COUNT_CAP);
		count_nx = count_q;
		addr_nx  = addr_q;
		func_nx  = func_q;
		crc_nx   = crc_q;
		d0_nx    = d0_q;
		d1_nx    = d1_q;
		if (take) begin
			count_nx = count_q + COUNT_W'(1);
			if (count_q == '0) begin
				addr_nx = item_s1.rx_byte;
			end
			if (count_q == COUNT_W'(1)) begin
				func_nx = item_s1.rx_byte;
			end
			if (count_q >= COUNT_W'(2)) begin
				crc_nx = crc_feed(crc_q, d0_q);
			end
			d0_nx = d1_q;
			d1_nx = item_s1.rx_byte;
		end
	end

	// frame checks, first failure wins
	assign sum_af = $signed({addr_nx[7], addr_nx}) + $signed({func_nx[7], func_nx});

	always_comb begin
		priority if (count_nx < COUNT_W'(2) || count_nx < {3'b000, min_len_q}) begin
			err = ERR_SHORT;
		end else if (strict_q && count_nx > max_len_q) begin
			err = ERR_LONG;
		end else if (strict_q && addr_nx != exp_addr_q) begin
			err = ERR_ADDR;
		end else if (strict_q && sum_af == 9'sd0) begin
			err = ERR_ZERO;
		end else if (d0_nx != crc_nx[7:0] || d1_nx != crc_nx[15:8]) begin
			err = ERR_CRC;
		end else begin
			err = ERR_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= CRC_INIT;
			d0_q    <= '0;
			d1_q    <= '0;
			count_q <= '0;
			addr_q  <= '0;
			func_q  <= '0;
		end else if (advance) begin
			if (item_s1.last_byte) begin
				crc_q   <= CRC_INIT;
				d0_q    <= '0;
				d1_q    <= '0;
				count_q <= '0;
				addr_q  <= '0;
				func_q  <= '0;
			end else begin
				crc_q   <= crc_nx;
				d0_q    <= d0_nx;
				d1_q    <= d1_nx;
				count_q <= count_nx;
				addr_q  <= addr_nx;
				func_q  <= func_nx;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && item_s1.last_byte) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.last_byte) begin
			res_q.frame_ok   <= (err == ERR_OK);
			res_q.error_code <= err;
			res_q.byte_count <= count_nx;
		end
	end

	assign result_valid = res_valid_q;
	assign result_data  = res_q;

	`ASSERT_CLK(a_ok_matches_code, result_valid |-> (result_data.frame_ok == (result_data.error_code == ERR_OK)), "frame_ok disagrees with error_code")
	`ASSERT_CLK(a_clear_after_last, (advance && item_s1.last_byte) |=> (count_q == '0 && crc_q == CRC_INIT), "frame state not cleared after last byte")
	`ASSERT_CLK(a_ok_has_trailer, (result_valid && result_data.frame_ok) |-> (result_data.byte_count >= COUNT_W'(2)), "passing frame shorter than its crc trailer")
	`ASSERT_ALWAYS(a_stall_needs_item, item_stall |-> (valid_s1 && res_valid_q && result_stall), "intake stalled without a blocked result")

endmodule
